// ===== hdl/gsrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrd_pkg
// Shared types and constants for the Gray-Scott reaction-diffusion step.
// ----------------------------------------------------------------------------
package gsrd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_RATE   = 3'd5;

    localparam logic [10:0] RST_ROW_LENGTH  = 11'd1024;
    localparam logic [10:0] RST_ROW_COUNT   = 11'd1024;
    localparam logic [15:0] RST_DIFFUSION_A = 16'd32768;
    localparam logic [15:0] RST_DIFFUSION_B = 16'd16384;
    localparam logic [15:0] RST_FEED_RATE   = 16'd3604;
    localparam logic [15:0] RST_KILL_RATE   = 16'd4063;

    localparam logic signed [33:0] EDGE_W   = 34'sd6554;
    localparam logic signed [33:0] CORNER_W = 34'sd1638;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_SUM1,
        ST_SUM2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_win;
        logic mul1;
        logic mul2;
        logic sum1;
        logic sum2;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic interior;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== hdl/gsrd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrd_ctrl
// Sequencer: steps one cell through load, multiply, sum and output phases;
// a border cell returns to idle after load.
module gsrd_ctrl
    import gsrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = i_stat.interior ? ST_MUL1 : ST_IDLE;
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_SUM1;
            ST_SUM1: n_state = ST_SUM2;
            ST_SUM2: n_state = ST_DONE;
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_LOAD: o_cmd.load_win = 1'b1;
            ST_MUL1: o_cmd.mul1 = 1'b1;
            ST_MUL2: o_cmd.mul2 = 1'b1;
            ST_SUM1: o_cmd.sum1 = 1'b1;
            ST_SUM2: o_cmd.sum2 = 1'b1;
            ST_DONE: o_cmd.out_load = !i_stat.out_busy;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== hdl/gsrd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrd_dp
// Datapath: config registers, position tracking, line buffers, 3x3 windows,
// Laplacian and reaction arithmetic, output register.
// ----------------------------------------------------------------------------
module gsrd_dp
    import gsrd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [15:0]           i_conc_a,
    input  logic [15:0]           i_conc_b,
    input  logic                  i_frame_start,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [15:0]           o_new_a,
    output logic [15:0]           o_new_b,
    output logic [9:0]            o_cell_row,
    output logic [9:0]            o_cell_col,
    output logic                  o_frame_last,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = 54;

    logic [10:0] r_row_length;
    logic [10:0] r_row_count;
    logic [15:0] r_dif_a;
    logic [15:0] r_dif_b;
    logic [15:0] r_feed;
    logic [15:0] r_kill;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [FW-1:0] r_fill;
    logic [CW-1:0] r_c;
    logic          r_int;
    logic          r_last;
    logic [9:0]    r_orow;
    logic [9:0]    r_ocol;
    logic [15:0]   r_ca;
    logic [15:0]   r_cb;

    logic [31:0] r_line1 [MAX_WIDTH];
    logic [31:0] r_line2 [MAX_WIDTH];
    logic [31:0] r_q1;
    logic [31:0] r_q2;
    logic        r_q_vld;
    logic [31:0] q1;
    logic [31:0] q2;

    logic [15:0] r_wa [9];
    logic [15:0] r_wb [9];

    logic signed [33:0] r_lap_a;
    logic signed [33:0] r_lap_b;
    logic [31:0]        r_ab;
    logic signed [33:0] r_fa;
    logic [32:0]        r_kfb;
    logic signed [50:0] r_dal;
    logic signed [50:0] r_dbl;
    logic [47:0]        r_abb;
    logic signed [SW-1:0] r_sa1;
    logic signed [SW-1:0] r_sa2;
    logic signed [SW-1:0] r_sb1;
    logic signed [SW-1:0] r_sb2;
    logic signed [SW-1:0] r_na;
    logic signed [SW-1:0] r_nb;

    logic        r_out_valid;
    logic [15:0] r_new_a;
    logic [15:0] r_new_b;
    logic [9:0]  r_cell_row;
    logic [9:0]  r_cell_col;
    logic        r_frame_last;

    logic [31:0] len32;
    logic [31:0] rows32;
    logic [31:0] c0;
    logic [31:0] r0;
    logic [31:0] cc;
    logic [31:0] rr;
    logic [31:0] cn;
    logic [31:0] rn;
    logic [31:0] rm1;
    logic [31:0] cm1;

    logic [17:0]        e_sum_a;
    logic [17:0]        k_sum_a;
    logic [17:0]        e_sum_b;
    logic [17:0]        k_sum_b;
    logic signed [33:0] lap_a;
    logic signed [33:0] lap_b;

    function automatic logic [15:0] to_q15(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        begin
            t = v + 54'sd536870912;
            if (v <= 0) begin
                to_q15 = 16'd0;
            end else if (v >= 54'sd35184372088832) begin
                to_q15 = 16'd32768;
            end else begin
                to_q15 = t[45:30];
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= RST_ROW_LENGTH;
            r_row_count  <= RST_ROW_COUNT;
            r_dif_a      <= RST_DIFFUSION_A;
            r_dif_b      <= RST_DIFFUSION_B;
            r_feed       <= RST_FEED_RATE;
            r_kill       <= RST_KILL_RATE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_LENGTH:  r_row_length <= i_cfg_data[10:0];
                CFG_ROW_COUNT:   r_row_count  <= i_cfg_data[10:0];
                CFG_DIFFUSION_A: r_dif_a      <= i_cfg_data;
                CFG_DIFFUSION_B: r_dif_b      <= i_cfg_data;
                CFG_FEED_RATE:   r_feed       <= i_cfg_data;
                CFG_KILL_RATE:   r_kill       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position of the arriving cell and of the next one
    always_comb begin
        len32 = {21'd0, r_row_length};
        if (len32 < 32'd3) begin
            len32 = 32'd3;
        end else if (len32 > 32'(MAX_WIDTH)) begin
            len32 = 32'(MAX_WIDTH);
        end
        rows32 = {21'd0, r_row_count};
        if (rows32 < 32'd3) begin
            rows32 = 32'd3;
        end else if (rows32 > 32'(MAX_HEIGHT)) begin
            rows32 = 32'(MAX_HEIGHT);
        end
        c0 = i_frame_start ? 32'd0 : 32'(r_col);
        r0 = i_frame_start ? 32'd0 : 32'(r_row);
        if (c0 >= len32) begin
            cc = 32'd0;
            rr = r0 + 32'd1;
        end else begin
            cc = c0;
            rr = r0;
        end
        if (rr >= rows32) begin
            rr = 32'd0;
        end
        cn = cc + 32'd1;
        rn = rr;
        if (cn >= len32) begin
            cn = 32'd0;
            rn = rr + 32'd1;
            if (rn >= rows32) begin
                rn = 32'd0;
            end
        end
        rm1 = rr - 32'd1;
        cm1 = cc - 32'd1;
    end

    // columns are written as a prefix from 0; r_fill marks how far it reaches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_int  <= 1'b0;
            r_fill <= '0;
        end else if (i_cmd.accept) begin
            r_col <= cn[CW-1:0];
            r_row <= rn[RW-1:0];
            r_int <= (rr >= 32'd2) && (cc >= 32'd2);
            if (cc >= 32'(r_fill)) begin
                r_fill <= FW'(cc + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c     <= cc[CW-1:0];
            r_last  <= (rr == rows32 - 32'd1) && (cc == len32 - 32'd1);
            r_orow  <= rm1[9:0];
            r_ocol  <= cm1[9:0];
            r_ca    <= i_conc_a;
            r_cb    <= i_conc_b;
            r_q1    <= r_line1[cc[CW-1:0]];
            r_q2    <= r_line2[cc[CW-1:0]];
            r_q_vld <= cc < 32'(r_fill);
        end
        if (i_cmd.load_win) begin
            r_line2[r_c] <= q1;
            r_line1[r_c] <= {r_cb, r_ca};
        end
    end

    // entries not yet written since reset read as zero
    assign q1 = r_q_vld ? r_q1 : '0;
    assign q2 = r_q_vld ? r_q2 : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_win) begin
            for (int y = 0; y < 3; y++) begin
                r_wa[y*3]   <= r_wa[y*3+1];
                r_wa[y*3+1] <= r_wa[y*3+2];
                r_wb[y*3]   <= r_wb[y*3+1];
                r_wb[y*3+1] <= r_wb[y*3+2];
            end
            r_wa[2] <= q2[15:0];
            r_wa[5] <= q1[15:0];
            r_wa[8] <= r_ca;
            r_wb[2] <= q2[31:16];
            r_wb[5] <= q1[31:16];
            r_wb[8] <= r_cb;
        end
    end

    always_comb begin
        e_sum_a = 18'(r_wa[1]) + 18'(r_wa[3]) + 18'(r_wa[5]) + 18'(r_wa[7]);
        k_sum_a = 18'(r_wa[0]) + 18'(r_wa[2]) + 18'(r_wa[6]) + 18'(r_wa[8]);
        e_sum_b = 18'(r_wb[1]) + 18'(r_wb[3]) + 18'(r_wb[5]) + 18'(r_wb[7]);
        k_sum_b = 18'(r_wb[0]) + 18'(r_wb[2]) + 18'(r_wb[6]) + 18'(r_wb[8]);
        lap_a = $signed({16'd0, e_sum_a}) * EDGE_W + $signed({16'd0, k_sum_a}) * CORNER_W
              - $signed({3'd0, r_wa[4], 15'd0});
        lap_b = $signed({16'd0, e_sum_b}) * EDGE_W + $signed({16'd0, k_sum_b}) * CORNER_W
              - $signed({3'd0, r_wb[4], 15'd0});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_lap_a <= lap_a;
            r_lap_b <= lap_b;
            r_ab    <= 32'(r_wa[4]) * 32'(r_wb[4]);
            r_fa    <= 34'($signed({1'b0, r_feed}))
                     * 34'($signed(17'd32768) - $signed({1'b0, r_wa[4]}));
            r_kfb   <= 33'(17'({1'b0, r_kill}) + 17'({1'b0, r_feed})) * 33'(r_wb[4]);
        end
        if (i_cmd.mul2) begin
            r_dal <= 51'($signed({1'b0, r_dif_a})) * 51'(r_lap_a);
            r_dbl <= 51'($signed({1'b0, r_dif_b})) * 51'(r_lap_b);
            r_abb <= 48'(r_ab) * 48'(r_wb[4]);
        end
        if (i_cmd.sum1) begin
            r_sa1 <= $signed({8'd0, r_wa[4], 30'd0}) + SW'(r_dal);
            r_sa2 <= (SW'(r_fa) <<< 14) - $signed({6'd0, r_abb});
            r_sb1 <= $signed({8'd0, r_wb[4], 30'd0}) + SW'(r_dbl);
            r_sb2 <= $signed({6'd0, r_abb}) - $signed({7'd0, r_kfb, 14'd0});
        end
        if (i_cmd.sum2) begin
            r_na <= r_sa1 + r_sa2;
            r_nb <= r_sb1 + r_sb2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_new_a      <= to_q15(r_na);
            r_new_b      <= to_q15(r_nb);
            r_cell_row   <= r_orow;
            r_cell_col   <= r_ocol;
            r_frame_last <= r_last;
        end
    end

    assign o_stat.interior = r_int;
    assign o_stat.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_new_a      = r_new_a;
    assign o_new_b      = r_new_b;
    assign o_cell_row   = r_cell_row;
    assign o_cell_col   = r_cell_col;
    assign o_frame_last = r_frame_last;

endmodule

// ===== hdl/gray_scott_reaction_diffusion_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_scott_reaction_diffusion_step_top
// The sequencer takes a new cell only while idle. An interior cell passes
// through the load, multiply, sum and done states; a border cell returns to
// idle after load. The done state holds while the output register is stalled.
// Reset clears position, sequencer state and output valid; config regs take
// their defaults. Line buffer columns beyond the fill count read as zero.
// ----------------------------------------------------------------------------
module gray_scott_reaction_diffusion_step_top
    import gsrd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_conc_a,
    input  logic [15:0]           i_conc_b,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_new_a,
    output logic [15:0]           o_new_b,
    output logic [9:0]            o_cell_row,
    output logic [9:0]            o_cell_col,
    output logic                  o_frame_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    gsrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gsrd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_conc_a      (i_conc_a),
        .i_conc_b      (i_conc_b),
        .i_frame_start (i_frame_start),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_new_a       (o_new_a),
        .o_new_b       (o_new_b),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_frame_last  (o_frame_last),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule
